FILE: rtl/dirty_range_tracker_assert.svh
// ----------------------------------------------------------------------------
// Dirty range tracker assertion macros
// Short forms for clocked assertions that are disabled while reset is active.
// ----------------------------------------------------------------------------
`ifndef DIRTY_RANGE_TRACKER_ASSERT_SVH
`define DIRTY_RANGE_TRACKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DRT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DRT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/drt_pkg.sv
// ----------------------------------------------------------------------------
// Dirty range tracker package
// Payload types, codes, sequencer states and small arithmetic helpers.
// ----------------------------------------------------------------------------
package drt_pkg;

	typedef enum logic [0:0] {
		KIND_PUSH    = 1'b0,
		KIND_COLLECT = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_REGION  = 2'd0,
		ST_PUSH_OK = 2'd1,
		ST_FULL    = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	typedef struct packed {
		kind_t       kind;
		logic [14:0] change_start;
		logic [15:0] change_length;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic [14:0] region_start;
		logic [15:0] region_length;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [14:0] start;
		logic [15:0] length;
	} entry_t;

	typedef struct packed {
		logic    valid;
		result_t data;
	} res_req_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRCH,
		S_DECIDE,
		S_SHIFT,
		S_INS,
		S_EMIT,
		C_LOAD,
		C_WALK,
		C_LAST
	} state_t;

	function automatic logic [15:0] sat_len(input logic [16:0] v);
		return v[16] ? 16'hFFFF : v[15:0];
	endfunction

	function automatic logic [16:0] max17(input logic [16:0] a, input logic [16:0] b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic [16:0] entry_end(input entry_t e);
		return {2'b00, e.start} + {1'b0, e.length};
	endfunction

endpackage

FILE: rtl/drt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module drt_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/drt_out.sv
// ----------------------------------------------------------------------------
// Dirty range tracker output register
// Holds one result until the receiver takes it and reports when it can load.
// ----------------------------------------------------------------------------
module drt_out (
	input  logic               clk,
	input  logic               arst_n,
	input  drt_pkg::res_req_t  res_req,
	output logic               slot_free,
	output logic               result_valid,
	input  logic               result_ready,
	output drt_pkg::result_t   result
);

	logic             valid_q;
	drt_pkg::result_t data_q;
	logic             load;

	assign slot_free    = !valid_q || result_ready;
	assign load         = res_req.valid && slot_free;
	assign result_valid = valid_q;
	assign result       = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (slot_free) begin
			valid_q <= res_req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res_req.data;
		end
	end

endmodule

FILE: rtl/drt_ctrl.sv
// ----------------------------------------------------------------------------
// Dirty range tracker sequencer
// Walks the RAM table one entry a cycle for search, shift, unstalled collect.
// ----------------------------------------------------------------------------
module drt_ctrl #(
	parameter int MAX_ENTRIES = 16,
	parameter int PAGE_BYTES  = 32768
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  drt_pkg::item_t                 item,
	output logic [$clog2(MAX_ENTRIES)-1:0] rd_addr,
	input  drt_pkg::entry_t                rd_data,
	output logic                           wr_en,
	output logic [$clog2(MAX_ENTRIES)-1:0] wr_addr,
	output drt_pkg::entry_t                wr_data,
	output drt_pkg::res_req_t              res_req,
	input  logic                           slot_free
);

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam logic [16:0] PageEnd = 17'(PAGE_BYTES);
	localparam logic [CW-1:0] MaxCount = CW'(MAX_ENTRIES);
	localparam logic [CW-1:0] OneC = CW'(1);
	localparam logic [AW-1:0] OneA = AW'(1);

	drt_pkg::state_t  state_q, state_d;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic [AW-1:0]    idx_q, idx_d;
	logic [CW-1:0]    pos_q, pos_d;
	logic             prev_vld_q, prev_vld_d;
	logic             cur_vld_q, cur_vld_d;
	logic [14:0]      s_q, s_d;
	logic [16:0]      end_q, end_d;
	logic [14:0]      prev_start_q, prev_start_d;
	logic [16:0]      prev_end_q, prev_end_d;
	logic [14:0]      cur_start_q, cur_start_d;
	logic [16:0]      cur_end_q, cur_end_d;
	logic [14:0]      cs_q, cs_d;
	logic [16:0]      ce_q, ce_d;
	drt_pkg::status_t status_q, status_d;

	logic [16:0]   sum_in;
	logic [16:0]   end_in;
	logic [16:0]   ent_end;
	logic [16:0]   ks;
	logic [CW-1:0] idx_nxt;
	logic          joins;
	logic          last_k;
	logic          adv;
	logic          merge_cur;
	logic          merge_prev;
	logic          full;

	always_comb begin
		sum_in = {2'b00, item.change_start} + {1'b0, item.change_length};
		// A start at or past the page end keeps zero length; else clamp the end.
		if ({2'b00, item.change_start} >= PageEnd) begin
			end_in = {2'b00, item.change_start};
		end else if (sum_in > PageEnd) begin
			end_in = PageEnd;
		end else begin
			end_in = sum_in;
		end
		ent_end    = drt_pkg::entry_end(rd_data);
		ks         = {2'b00, rd_data.start};
		idx_nxt    = CW'(idx_q) + OneC;
		joins      = ({2'b00, cs_q} <= ks) && (ks <= ce_q);
		last_k     = (idx_nxt == cnt_q);
		adv        = joins || slot_free;
		merge_cur  = cur_vld_q && ({2'b00, cur_start_q} <= end_q);
		merge_prev = prev_vld_q && ({2'b00, s_q} <= prev_end_q);
		full       = (cnt_q >= MaxCount);
	end

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		idx_d        = idx_q;
		pos_d        = pos_q;
		prev_vld_d   = prev_vld_q;
		cur_vld_d    = cur_vld_q;
		s_d          = s_q;
		end_d        = end_q;
		prev_start_d = prev_start_q;
		prev_end_d   = prev_end_q;
		cur_start_d  = cur_start_q;
		cur_end_d    = cur_end_q;
		cs_d         = cs_q;
		ce_d         = ce_q;
		status_d     = status_q;
		item_ready   = 1'b0;
		rd_addr      = '0;
		wr_en        = 1'b0;
		wr_addr      = AW'(pos_q);
		wr_data      = rd_data;
		res_req      = '0;

		unique case (state_q)
			drt_pkg::S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					s_d        = item.change_start;
					end_d      = end_in;
					prev_vld_d = 1'b0;
					cur_vld_d  = 1'b0;
					idx_d      = '0;
					pos_d      = '0;
					if (item.kind == drt_pkg::KIND_PUSH) begin
						state_d = (cnt_q == '0) ? drt_pkg::S_DECIDE : drt_pkg::S_SRCH;
					end else if (cnt_q == '0) begin
						status_d = drt_pkg::ST_EMPTY;
						state_d  = drt_pkg::S_EMIT;
					end else begin
						state_d = drt_pkg::C_LOAD;
					end
				end
			end

			drt_pkg::S_SRCH: begin
				// Entry idx_q arrives; the next one is requested in the same cycle.
				rd_addr = AW'(idx_nxt);
				if (rd_data.start < s_q) begin
					prev_vld_d   = 1'b1;
					prev_start_d = rd_data.start;
					prev_end_d   = ent_end;
					if (idx_nxt == cnt_q) begin
						pos_d   = cnt_q;
						state_d = drt_pkg::S_DECIDE;
					end else begin
						idx_d = AW'(idx_nxt);
					end
				end else begin
					cur_vld_d   = 1'b1;
					cur_start_d = rd_data.start;
					cur_end_d   = ent_end;
					pos_d       = CW'(idx_q);
					state_d     = drt_pkg::S_DECIDE;
				end
			end

			drt_pkg::S_DECIDE: begin
				rd_addr  = AW'(cnt_q - OneC);
				status_d = drt_pkg::ST_PUSH_OK;
				if (merge_cur) begin
					wr_en         = 1'b1;
					wr_addr       = AW'(pos_q);
					wr_data.start = s_q;
					wr_data.length = drt_pkg::sat_len(
						drt_pkg::max17(end_q, cur_end_q) - {2'b00, s_q});
					state_d       = drt_pkg::S_EMIT;
				end else if (merge_prev) begin
					wr_en         = 1'b1;
					wr_addr       = AW'(pos_q - OneC);
					wr_data.start = prev_start_q;
					wr_data.length = drt_pkg::sat_len(
						drt_pkg::max17(prev_end_q, end_q) - {2'b00, prev_start_q});
					state_d       = drt_pkg::S_EMIT;
				end else if (full) begin
					status_d = drt_pkg::ST_FULL;
					state_d  = drt_pkg::S_EMIT;
				end else if (pos_q == cnt_q) begin
					state_d = drt_pkg::S_INS;
				end else begin
					idx_d   = AW'(cnt_q - OneC);
					state_d = drt_pkg::S_SHIFT;
				end
			end

			drt_pkg::S_SHIFT: begin
				// Move entry idx_q up by one, working down towards the insert point.
				wr_en   = 1'b1;
				wr_addr = AW'(idx_nxt);
				wr_data = rd_data;
				rd_addr = idx_q - OneA;
				if (CW'(idx_q) == pos_q) begin
					state_d = drt_pkg::S_INS;
				end else begin
					idx_d = idx_q - OneA;
				end
			end

			drt_pkg::S_INS: begin
				wr_en          = 1'b1;
				wr_addr        = AW'(pos_q);
				wr_data.start  = s_q;
				wr_data.length = drt_pkg::sat_len(end_q - {2'b00, s_q});
				cnt_d          = cnt_q + OneC;
				status_d       = drt_pkg::ST_PUSH_OK;
				state_d        = drt_pkg::S_EMIT;
			end

			drt_pkg::S_EMIT: begin
				res_req.valid       = 1'b1;
				res_req.data.status = status_q;
				res_req.data.last   = 1'b1;
				if (slot_free) begin
					state_d = drt_pkg::S_IDLE;
				end
			end

			drt_pkg::C_LOAD: begin
				cs_d    = rd_data.start;
				ce_d    = ent_end;
				rd_addr = OneA;
				idx_d   = OneA;
				state_d = (cnt_q == OneC) ? drt_pkg::C_LAST : drt_pkg::C_WALK;
			end

			drt_pkg::C_WALK: begin
				if (!joins) begin
					res_req.valid              = 1'b1;
					res_req.data.status        = drt_pkg::ST_REGION;
					res_req.data.region_start  = cs_q;
					res_req.data.region_length = drt_pkg::sat_len(ce_q - {2'b00, cs_q});
				end
				// Blocked output, no join: the read address holds, so the data stays.
				rd_addr = (adv && !last_k) ? AW'(idx_nxt) : idx_q;
				if (adv) begin
					if (joins) begin
						ce_d = drt_pkg::max17(ce_q, ent_end);
					end else begin
						cs_d = rd_data.start;
						ce_d = ent_end;
					end
					if (last_k) begin
						state_d = drt_pkg::C_LAST;
					end else begin
						idx_d = AW'(idx_nxt);
					end
				end
			end

			drt_pkg::C_LAST: begin
				res_req.valid              = 1'b1;
				res_req.data.status        = drt_pkg::ST_REGION;
				res_req.data.region_start  = cs_q;
				res_req.data.region_length = drt_pkg::sat_len(ce_q - {2'b00, cs_q});
				res_req.data.last          = 1'b1;
				if (slot_free) begin
					cnt_d   = '0;
					state_d = drt_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = drt_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= drt_pkg::S_IDLE;
			cnt_q      <= '0;
			prev_vld_q <= 1'b0;
			cur_vld_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			cnt_q      <= cnt_d;
			prev_vld_q <= prev_vld_d;
			cur_vld_q  <= cur_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q        <= idx_d;
		pos_q        <= pos_d;
		s_q          <= s_d;
		end_q        <= end_d;
		prev_start_q <= prev_start_d;
		prev_end_q   <= prev_end_d;
		cur_start_q  <= cur_start_d;
		cur_end_q    <= cur_end_d;
		cs_q         <= cs_d;
		ce_q         <= ce_d;
		status_q     <= status_d;
	end

endmodule

FILE: rtl/dirty_range_tracker.sv
// ----------------------------------------------------------------------------
// Dirty range tracker
// Sorted table of changed byte ranges of one page, merged on push and collect.
// ----------------------------------------------------------------------------
// Usage: items arrive on item_valid/item_ready carrying a kind, a start and a
// length. A push transaction yields one result (accepted or table full); a
// collect transaction yields one result per merged region, the final one with
// last set, or a single "nothing to collect" result on an empty table.
// The table lives in a single RAM and is visited one entry per cycle, but a
// collect walk holds when a region meets a blocked output. A push searches the
// table, then merges into an entry or is refused, or, when it inserts, shifts
// the entries from the insert point up by one and writes the new entry. A
// collect reads every entry of the table in order; on an empty table it goes
// straight to its result. Each result passes through the output register
// before it reaches result_valid, and the sequencer returns to idle between
// transactions; item_ready is high only while idle.
// Results wait in an output register, so the sequencer may finish and accept
// the next transaction while the last result is still held. A stalled
// receiver holds a push at its result, a collect at a region, until drained.
// Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module dirty_range_tracker #(
	parameter int MAX_ENTRIES = 16,
	parameter int PAGE_BYTES  = 32768
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  drt_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output drt_pkg::result_t result
);

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int EW = $bits(drt_pkg::entry_t);

	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     wr_addr;
	logic              wr_en;
	drt_pkg::entry_t   rd_data;
	drt_pkg::entry_t   wr_data;
	logic [EW-1:0]     rd_bits;
	drt_pkg::res_req_t res_req;
	logic              slot_free;

	assign rd_data = drt_pkg::entry_t'(rd_bits);

	drt_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(rd_addr),
		.rdata(rd_bits)
	);

	drt_ctrl #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.PAGE_BYTES (PAGE_BYTES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item      (item),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.res_req   (res_req),
		.slot_free (slot_free)
	);

	drt_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.res_req     (res_req),
		.slot_free   (slot_free),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

endmodule

FILE: rtl/drt_chk.sv
// ----------------------------------------------------------------------------
// Dirty range tracker checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module drt_chk (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_ready,
	input drt_pkg::item_t   item,
	input logic             result_valid,
	input logic             result_ready,
	input drt_pkg::result_t result
);

`include "dirty_range_tracker_assert.svh"

	// Every accepted transaction makes the block busy: item_ready is low after it.
	`DRT_ASSERT_NEXT(a_busy_after_accept, item_valid && item_ready, !item_ready, "ready after accept")

	`DRT_ASSERT_NOW(a_status_last, result_valid && result.status != drt_pkg::ST_REGION, result.last, "status result without last")

	`DRT_ASSERT_NOW(a_status_zero, result_valid && result.status != drt_pkg::ST_REGION, result.region_start == '0 && result.region_length == '0, "status result with region fields")

	`DRT_ASSERT_NEXT(a_item_hold, item_valid && !item_ready, item_valid && $stable(item), "item dropped or changed")

	`DRT_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "result dropped or changed")

endmodule

bind dirty_range_tracker drt_chk u_chk (.*);

FILE: tb/sv/drt_checker.sv
// ----------------------------------------------------------------------------
// Dirty range tracker checker
// Watches both channels of the tracker, keeps its own copy of the range table,
// works out the results of every accepted item and compares them, field by
// field and in order, with the results the block hands out.
// ----------------------------------------------------------------------------
module drt_checker #(
	parameter int MAX_ENTRIES = 16,
	parameter int PAGE_BYTES  = 32768
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_ready,
	input  drt_pkg::item_t   item,
	input  logic             result_valid,
	input  logic             result_ready,
	input  drt_pkg::result_t result,
	output int               mismatches,
	output int               pending
);

	bit [14:0]        tab_start [MAX_ENTRIES];
	bit [15:0]        tab_len   [MAX_ENTRIES];
	int               used = 0;
	drt_pkg::result_t pending_results [$];
	int               fail_tally = 0;
	int               due_count  = 0;

	assign mismatches = fail_tally;
	assign pending    = due_count;

	function automatic bit [15:0] clip_len(input int v);
		return (v > 65535) ? 16'hFFFF : 16'(v);
	endfunction

	function automatic void expect_result(input drt_pkg::status_t st, input int s,
			input int l, input logic fin);
		drt_pkg::result_t r;
		r.status        = st;
		r.region_start  = 15'(s);
		r.region_length = 16'(l);
		r.last          = fin;
		pending_results.push_back(r);
	endfunction

	// Merge into the first entry at or after the new start, else into the one
	// before it, else insert in order, if not full. No further merging happens.
	function automatic drt_pkg::status_t push_range(input int s, input int len);
		int fin;
		int i;
		int k;
		int e1;
		int e2;
		fin = s + len;
		if (s >= PAGE_BYTES) begin
			fin = s;
		end else if (fin > PAGE_BYTES) begin
			fin = PAGE_BYTES;
		end
		i = 0;
		while (i < used && int'(tab_start[i]) < s)
			i++;
		if (i < used && int'(tab_start[i]) <= fin) begin
			e2 = int'(tab_start[i]) + int'(tab_len[i]);
			tab_start[i] = 15'(s);
			tab_len[i]   = clip_len(((fin > e2) ? fin : e2) - s);
			return drt_pkg::ST_PUSH_OK;
		end
		if (i > 0) begin
			e1 = int'(tab_start[i-1]) + int'(tab_len[i-1]);
			if (s <= e1) begin
				tab_len[i-1] = clip_len(((e1 > fin) ? e1 : fin) - int'(tab_start[i-1]));
				return drt_pkg::ST_PUSH_OK;
			end
		end
		if (used >= MAX_ENTRIES)
			return drt_pkg::ST_FULL;
		for (k = used; k > i; k--) begin
			tab_start[k] = tab_start[k-1];
			tab_len[k]   = tab_len[k-1];
		end
		tab_start[i] = 15'(s);
		tab_len[i]   = clip_len(fin - s);
		used++;
		return drt_pkg::ST_PUSH_OK;
	endfunction

	function automatic void collect_regions();
		int run_s;
		int run_e;
		int ks;
		int ke;
		int k;
		if (used == 0) begin
			expect_result(drt_pkg::ST_EMPTY, 0, 0, 1'b1);
			return;
		end
		run_s = int'(tab_start[0]);
		run_e = run_s + int'(tab_len[0]);
		for (k = 1; k < used; k++) begin
			ks = int'(tab_start[k]);
			ke = ks + int'(tab_len[k]);
			if (run_s <= ks && ks <= run_e) begin
				if (ke > run_e)
					run_e = ke;
			end else begin
				expect_result(drt_pkg::ST_REGION, run_s, clip_len(run_e - run_s), 1'b0);
				run_s = ks;
				run_e = ke;
			end
		end
		expect_result(drt_pkg::ST_REGION, run_s, clip_len(run_e - run_s), 1'b1);
		used = 0;
	endfunction

	// Results are matched before the item of the same edge is predicted; a
	// result can never belong to an item accepted at that very edge.
	always @(posedge clk) begin
		drt_pkg::result_t want;
		int               bad;
		bad = 0;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (pending_results.size() == 0) begin
					$error("result transaction with nothing pending: status %0d start %0d",
						result.status, result.region_start);
					bad++;
				end else begin
					want = pending_results.pop_front();
					if (result.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result.status);
						bad++;
					end
					if (result.region_start !== want.region_start) begin
						$error("region_start: expected %0d, got %0d",
							want.region_start, result.region_start);
						bad++;
					end
					if (result.region_length !== want.region_length) begin
						$error("region_length: expected %0d, got %0d",
							want.region_length, result.region_length);
						bad++;
					end
					if (result.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, result.last);
						bad++;
					end
				end
			end
			if (item_valid && item_ready) begin
				if (item.kind == drt_pkg::KIND_PUSH) begin
					expect_result(push_range(item.change_start, item.change_length),
						0, 0, 1'b1);
				end else begin
					collect_regions();
				end
			end
		end
		fail_tally <= fail_tally + bad;
		due_count  <= pending_results.size();
	end

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Dirty range tracker testbench
// Drives push and collect transactions into the tracker: a directed run over
// the merge, insert, full-table and empty-collect cases, then random phases
// with sender idling, receiver stalls and one long receiver hold-off. The
// checker beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             item_valid   = 1'b0;
	logic             item_ready;
	drt_pkg::item_t   item         = '0;
	logic             result_valid;
	logic             result_ready = 1'b0;
	drt_pkg::result_t result;

	int   mismatches;
	int   pending;
	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	logic hold_req       = 1'b0;
	logic hold_seen      = 1'b0;
	int   hold_left      = 0;
	int   cycle_count    = 0;

	always #10 clk = ~clk;

	dirty_range_tracker u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	drt_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.mismatches  (mismatches),
		.pending     (pending)
	);

	// Receiver: random stalls, plus one long hold-off counted here.
	always @(posedge clk) begin
		if (hold_req && !hold_seen)
			hold_left = HOLD_CYCLES;
		hold_seen = hold_req;
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("dirty_range_tracker test failed");
			$finish;
		end
	end

	task automatic offer(input drt_pkg::kind_t k, input int s, input int l);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= '{kind: k, change_start: 15'(s), change_length: 16'(l)};
		do
			@(posedge clk);
		while (!item_ready);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	int idle_tab  [4] = '{0, 57, 0, 30};
	int stall_tab [4] = '{0, 0, 57, 30};

	initial begin
		int ph;
		int n;
		int pick;
		int s;
		int l;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty collect, both merge directions, insert, coalescing.
		offer(drt_pkg::KIND_COLLECT, 32767, 65535);
		offer(drt_pkg::KIND_PUSH, 100, 50);
		offer(drt_pkg::KIND_PUSH, 150, 10);
		offer(drt_pkg::KIND_PUSH, 90, 5);
		offer(drt_pkg::KIND_PUSH, 95, 5);
		offer(drt_pkg::KIND_COLLECT, 0, 0);
		// Fill the table with separate ranges: a zero-length one at offset zero
		// and one at the top whose end runs past the page.
		for (n = 0; n < 16; n++)
			offer(drt_pkg::KIND_PUSH, n * 2048, (n == 15) ? 65535 : ((n == 0) ? 0 : 16));
		offer(drt_pkg::KIND_PUSH, 1000, 8);
		offer(drt_pkg::KIND_PUSH, 2064, 4);
		offer(drt_pkg::KIND_COLLECT, 12345, 32768);
		drain();

		for (ph = 0; ph < 4; ph++) begin
			send_idle_pct  = idle_tab[ph];
			recv_stall_pct <= stall_tab[ph];
			if (ph == 2)
				hold_req <= 1'b1;
			for (n = 0; n < 64; n++) begin
				pick = $urandom_range(99);
				if (pick < 8) begin
					offer(drt_pkg::KIND_COLLECT, $urandom_range(32767),
						$urandom_range(65535));
				end else begin
					// Clustered starts make merges and a full table common.
					if ($urandom_range(1))
						s = $urandom_range(31) * 1024 + $urandom_range(31);
					else
						s = $urandom_range(32767);
					pick = $urandom_range(9);
					if (pick < 6)
						l = $urandom_range(48);
					else if (pick == 6)
						l = 0;
					else if (pick == 7)
						l = $urandom_range(65535);
					else
						l = $urandom_range(1024, 4096);
					offer(drt_pkg::KIND_PUSH, s, l);
				end
			end
			drain();
		end

		repeat (50) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("dirty_range_tracker test passed");
		end else begin
			$display("dirty_range_tracker test failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/drt_pkg.sv
rtl/drt_ram.sv
rtl/drt_out.sv
rtl/drt_ctrl.sv
rtl/dirty_range_tracker.sv
rtl/drt_chk.sv
tb/sv/drt_checker.sv
tb/sv/tb_top.sv
